### hw/rtl/sab_pkg.sv
// Shared constants, codes and controller/datapath interface types for the slab bump allocator.
`timescale 1ns / 1ps

package sab_pkg;

  localparam int unsigned DEF_MAX_SLABS      = 32;
  localparam int unsigned DEF_ALIGN_BYTES    = 256;
  localparam int unsigned DEF_MIN_SLAB_BYTES = 4194304;

  localparam int unsigned REQ_W   = 32;
  localparam int unsigned BYTES_W = 33;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned SLAB_W  = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_IW  = 1;

  localparam logic [BYTES_W-1:0] RESET_MAX_TOTAL = 33'd67108864;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_MAX_TOTAL = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_CAPTURE   = 1'd1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_EXIST    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_CAPTURE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CAPACITY = 3'd3;
  localparam logic [STAT_W-1:0] STAT_GEN      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic align;
    logic walk;
    logic grow;
    logic gen;
  } sab_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic align_done;
    logic walk_end;
    logic walk_hit;
  } sab_stat_t;

endpackage

### hw/rtl/sab_ctrl.sv
// Controller state machine that sequences align, slab walk, growth and generation items.
`timescale 1ns / 1ps

module sab_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_action,
  input  sab_pkg::sab_stat_t stat,
  output sab_pkg::sab_cmd_t  cmd,
  output logic               busy
);
  import sab_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_GROW  = 3'd3;
  localparam logic [2:0] S_GEN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_action ? S_GEN : S_ALIGN;
        end
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        if (stat.align_done) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        priority if (stat.walk_end) begin
          state_nxt = S_GROW;
        end else if (stat.walk_hit) begin
          state_nxt = S_IDLE;
        end
      end
      S_GROW: begin
        cmd.grow  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_GEN: begin
        cmd.gen   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/sab_datapath.sv
// Datapath: size rounding, slab size memory, cursor walk, growth checks and result registers.
`timescale 1ns / 1ps

module sab_datapath #(
  parameter int unsigned MAX_SLABS      = sab_pkg::DEF_MAX_SLABS,
  parameter int unsigned MIN_SLAB_BYTES = sab_pkg::DEF_MIN_SLAB_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sab_pkg::sab_cmd_t                   cmd,
  output sab_pkg::sab_stat_t                  stat,
  input  logic [sab_pkg::REQ_W-1:0]           in_request_bytes,
  input  logic                                cfg_we,
  input  logic [sab_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [sab_pkg::BYTES_W-1:0]         cfg_wdata,
  output logic                                out_valid,
  output logic [sab_pkg::STAT_W-1:0]          out_status,
  output logic                                out_granted,
  output logic [sab_pkg::SLAB_W-1:0]          out_region_slab,
  output logic [sab_pkg::REQ_W-1:0]           out_region_offset,
  output logic [sab_pkg::REQ_W-1:0]           out_region_logical_start,
  output logic [sab_pkg::BYTES_W-1:0]         out_bytes_in_use,
  output logic [sab_pkg::BYTES_W-1:0]         out_peak_bytes,
  output logic [sab_pkg::GEN_W-1:0]           out_generation_number
);
  import sab_pkg::*;

  localparam int unsigned IW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLABS + 1);
  localparam logic [BYTES_W-1:0] ALIGN_C = BYTES_W'(DEF_ALIGN_BYTES);
  localparam logic [BYTES_W-1:0] MIN_C   = BYTES_W'(MIN_SLAB_BYTES);
  localparam logic [CW-1:0]      SLABS_C = CW'(MAX_SLABS);

  // Slab size store; only entries below the slab count are ever used.
  logic [BYTES_W-1:0] slab_mem [MAX_SLABS];
  logic [BYTES_W-1:0] rd_q_r;
  logic [IW-1:0]      rd_addr;

  logic [REQ_W-1:0]   req_r;
  logic [BYTES_W-1:0] aligned_r;
  logic [BYTES_W-1:0] aligned_val;
  logic [CW-1:0]      idx_r;
  logic [BYTES_W-1:0] base_r;

  logic [CW-1:0]      count_r;
  logic [BYTES_W-1:0] cursor_r;
  logic [BYTES_W-1:0] total_r;
  logic [GEN_W-1:0]   gen_r;
  logic [BYTES_W-1:0] hw_r;
  logic [BYTES_W-1:0] max_total_r;
  logic               capture_r;

  logic [BYTES_W:0]   end_sum;
  logic [BYTES_W:0]   cur_plus;
  logic               cur_lt;
  logic               walk_end;
  logic               walk_hit;
  logic [BYTES_W-1:0] new_cursor;
  logic [BYTES_W-1:0] hw_nxt;
  logic [BYTES_W-1:0] new_size;
  logic [BYTES_W:0]   grow_sum;
  logic               cap_fail;

  // The alignment is a power of two, so rounding up is an add and a mask.
  assign aligned_val = ({1'b0, req_r} + (ALIGN_C - BYTES_W'(1))) &
                       ~(ALIGN_C - BYTES_W'(1));
  assign stat.align_done = 1'b1;

  // One slab per cycle: the read data for the current index is already registered.
  assign walk_end   = (idx_r >= count_r);
  assign end_sum    = {1'b0, base_r} + {1'b0, rd_q_r};
  assign cur_plus   = {1'b0, cursor_r} + {1'b0, aligned_r};
  assign cur_lt     = ({1'b0, cursor_r} < end_sum);
  assign walk_hit   = !walk_end && cur_lt && (cur_plus <= end_sum);
  assign new_cursor = cur_plus[BYTES_W-1:0];
  assign hw_nxt     = (new_cursor > hw_r) ? new_cursor : hw_r;

  assign stat.walk_end = walk_end;
  assign stat.walk_hit = walk_hit;

  assign new_size = (aligned_r > MIN_C) ? aligned_r : MIN_C;
  assign grow_sum = {1'b0, total_r} + {1'b0, new_size};
  assign cap_fail = (total_r >= max_total_r) || (grow_sum > {1'b0, max_total_r}) ||
                    (count_r >= SLABS_C);

  assign rd_addr = (cmd.walk && !walk_end && !walk_hit) ?
                   IW'(idx_r + CW'(1)) : idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    rd_q_r <= slab_mem[rd_addr];
    if (cmd.grow && !capture_r && !cap_fail) begin
      slab_mem[count_r[IW-1:0]] <= new_size;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_request_bytes;
      idx_r  <= '0;
      base_r <= '0;
    end else if (cmd.align) begin
      aligned_r <= aligned_val;
    end else if (cmd.walk && !walk_end && !walk_hit) begin
      idx_r  <= idx_r + CW'(1);
      base_r <= end_sum[BYTES_W-1:0];
    end
  end

  // Allocator state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      total_r     <= '0;
      gen_r       <= '0;
      hw_r        <= '0;
      max_total_r <= RESET_MAX_TOTAL;
      capture_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_TOTAL: max_total_r <= cfg_wdata;
          CFG_CAPTURE:   capture_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.gen) begin
        gen_r    <= gen_r + GEN_W'(1);
        cursor_r <= '0;
      end else if (cmd.walk && !walk_end) begin
        if (walk_hit) begin
          cursor_r <= new_cursor;
          hw_r     <= hw_nxt;
        end else if (cur_lt) begin
          // The rest of this slab is abandoned.
          cursor_r <= end_sum[BYTES_W-1:0];
        end
      end else if (cmd.grow && !capture_r && !cap_fail) begin
        count_r  <= count_r + CW'(1);
        total_r  <= grow_sum[BYTES_W-1:0];
        cursor_r <= new_cursor;
        hw_r     <= hw_nxt;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.gen || (cmd.walk && walk_hit) || cmd.grow;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen) begin
      out_status               <= STAT_GEN;
      out_granted              <= 1'b0;
      out_region_slab          <= '0;
      out_region_offset        <= '0;
      out_region_logical_start <= '0;
      out_bytes_in_use         <= '0;
      out_peak_bytes           <= hw_r;
      out_generation_number    <= gen_r + GEN_W'(1);
    end else if (cmd.walk && walk_hit) begin
      out_status               <= STAT_EXIST;
      out_granted              <= 1'b1;
      out_region_slab          <= SLAB_W'(idx_r[IW-1:0]);
      out_region_offset        <= REQ_W'(cursor_r - base_r);
      out_region_logical_start <= cursor_r[REQ_W-1:0];
      out_bytes_in_use         <= new_cursor;
      out_peak_bytes           <= hw_nxt;
      out_generation_number    <= gen_r;
    end else if (cmd.grow) begin
      out_region_offset     <= '0;
      out_generation_number <= gen_r;
      if (capture_r || cap_fail) begin
        out_status               <= capture_r ? STAT_CAPTURE : STAT_CAPACITY;
        out_granted              <= 1'b0;
        out_region_slab          <= '0;
        out_region_logical_start <= '0;
        out_bytes_in_use         <= cursor_r;
        out_peak_bytes           <= hw_r;
      end else begin
        out_status               <= STAT_NEW;
        out_granted              <= 1'b1;
        out_region_slab          <= SLAB_W'(count_r[IW-1:0]);
        out_region_logical_start <= cursor_r[REQ_W-1:0];
        out_bytes_in_use         <= new_cursor;
        out_peak_bytes           <= hw_nxt;
      end
    end
  end

endmodule

### hw/rtl/slab_arena_bump_allocator.sv
// Top level of the slab bump allocator: controller, datapath and interface checks.
`timescale 1ns / 1ps
// Usage:
// A command is taken at a clock edge where start is high and busy is low; in_action
// selects a reserve (0) or a new generation (1), in_request_bytes is the reserve size.
// Exactly one result follows each command; it is shown for one cycle with out_valid
// high and must be taken then, since the receiver cannot hold results off.
// A reserve rounds its size up to the fixed power-of-two alignment, then walks the
// slab size memory one slab per cycle from the first slab, stopping at the first
// slab that fits; at the end of the walk it grows a new slab if no slab fits.
// The slab walk sets how long a reserve takes.
// One command is in flight at a time; busy drops in the cycle its result is shown,
// so the next command can be taken there.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and must be
// made while the block is idle; the block does not enforce this. Reset (rst_n low,
// synchronous) clears slab count, cursor, total, peak and generation count, restores
// register defaults; slab sizes need no clearing: only those below the count are used.
module slab_arena_bump_allocator #(
  parameter int unsigned MAX_SLABS      = sab_pkg::DEF_MAX_SLABS,
  parameter int unsigned MIN_SLAB_BYTES = sab_pkg::DEF_MIN_SLAB_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [sab_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic                        cfg_we,
  input  logic [sab_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sab_pkg::BYTES_W-1:0] cfg_wdata,
  output logic                        out_valid,
  output logic [sab_pkg::STAT_W-1:0]  out_status,
  output logic                        out_granted,
  output logic [sab_pkg::SLAB_W-1:0]  out_region_slab,
  output logic [sab_pkg::REQ_W-1:0]   out_region_offset,
  output logic [sab_pkg::REQ_W-1:0]   out_region_logical_start,
  output logic [sab_pkg::BYTES_W-1:0] out_bytes_in_use,
  output logic [sab_pkg::BYTES_W-1:0] out_peak_bytes,
  output logic [sab_pkg::GEN_W-1:0]   out_generation_number
);
  import sab_pkg::*;

  sab_cmd_t  cmd;
  sab_stat_t stat;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  sab_datapath #(
    .MAX_SLABS      (MAX_SLABS),
    .MIN_SLAB_BYTES (MIN_SLAB_BYTES)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .stat                     (stat),
    .in_request_bytes         (in_request_bytes),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .out_valid                (out_valid),
    .out_status               (out_status),
    .out_granted              (out_granted),
    .out_region_slab          (out_region_slab),
    .out_region_offset        (out_region_offset),
    .out_region_logical_start (out_region_logical_start),
    .out_bytes_in_use         (out_bytes_in_use),
    .out_peak_bytes           (out_peak_bytes),
    .out_generation_number    (out_generation_number)
  );

  // A result always ends its command, so the block is idle while it is shown.
  a_result_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a command is still in flight");

  // A new-generation command returns its result through the controller state register and then the result register.
  a_gen_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |-> ##2 (out_valid && (out_status == STAT_GEN)))
    else $error("generation result missing");

  // Grants carry only grant codes.
  a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |->
      ((out_status == STAT_EXIST) || (out_status == STAT_NEW)))
    else $error("grant with a refusal status");

  // The peak never lags the cursor reported at a grant.
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (out_peak_bytes >= out_bytes_in_use))
    else $error("peak below cursor after a grant");

endmodule
